FILE: rtl/lbcg_pkg.sv
package lbcg_pkg;

    localparam int VALUE_W = 32;
    localparam int UNIT_W = 23;
    localparam int COUNT_W = 8;
    localparam int DIGIT_CNT_W = 4;
    localparam int NIBBLE_W = 4;
    localparam int OUT_TDATA_W = 8;

    localparam logic [UNIT_W-1:0] UNIT_RESET = 23'h100000;
    localparam logic [NIBBLE_W-1:0] NIBBLE_MASK = 4'hf;
    localparam logic [COUNT_W-1:0] LONG_FLASH_UNITS = 8'd5;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_WORD  = 2'd1,
        KIND_COUNT = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_FLASH = 2'd1,
        PH_SPACE = 2'd2,
        PH_GAP   = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        LEN_QUARTER = 2'd0,
        LEN_ONE     = 2'd1,
        LEN_FOUR    = 2'd2
    } flen_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [VALUE_W-1:0] value;
    } item_t;

    typedef struct packed {
        logic start_ignored;
        logic done_res;
        logic busy_res;
        logic led;
    } res_t;

    typedef struct packed {
        logic [COUNT_W-1:0] remaining;
        flen_t              flen;
    } plan_t;

endpackage

FILE: rtl/lbcg_in_stage.sv
module lbcg_in_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,
    input  logic [1:0]           s_tuser,
    input  logic                 down_ready,
    output logic                 item_valid,
    output lbcg_pkg::item_t      item
);
    import lbcg_pkg::*;

    logic  valid_reg, valid_next;
    item_t item_reg;

    assign s_tready = !valid_reg || down_ready;

    always_comb begin
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (down_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.kind  <= s_tuser;
            item_reg.value <= s_tdata;
        end
    end

    assign item_valid = valid_reg;
    assign item = item_reg;

endmodule

FILE: rtl/lbcg_core.sv
module lbcg_core #(
    parameter int DIGITS = 8,
    parameter int TICK_COUNT_WIDTH = 24
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    input  logic [lbcg_pkg::UNIT_W-1:0]  cfg_data,
    input  logic                         step,
    input  lbcg_pkg::item_t              item,
    output lbcg_pkg::res_t               res
);
    import lbcg_pkg::*;

    localparam int TCW = TICK_COUNT_WIDTH;
    localparam int LEN_W = (TCW + 1 > UNIT_W + 2) ? TCW + 1 : UNIT_W + 2;
    localparam int WORD_SHIFT = (DIGITS < 8) ? NIBBLE_W * (8 - DIGITS) : 0;
    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(1) << TCW;
    localparam logic [DIGIT_CNT_W-1:0] LAST_DIGIT = DIGIT_CNT_W'(DIGITS - 1);

    logic [UNIT_W-1:0]      unit_reg;
    phase_t                 phase_reg, phase_next;
    logic [TCW-1:0]         tick_reg, tick_next;
    logic [COUNT_W-1:0]     rem_reg, rem_next;
    flen_t                  flen_reg, flen_next;
    logic [DIGIT_CNT_W-1:0] digits_reg, digits_next;
    logic [VALUE_W-1:0]     word_reg, word_next;
    logic                   led_reg, led_next;

    logic [LEN_W-1:0]       raw_len, seg_len, tick_inc;
    logic [VALUE_W-1:0]     word_shifted, word_start;
    logic                   done, ignored;
    plan_t                  plan;

    // Splits what is left of a digit into the next flash: a long flash per
    // whole five, otherwise a short one; a zero digit gets the quarter flash.
    function automatic plan_t flash_plan(input logic [COUNT_W-1:0] d);
        plan_t p;
        if (d == '0) begin
            p.remaining = '0;
            p.flen = LEN_QUARTER;
        end else if (d >= LONG_FLASH_UNITS) begin
            p.remaining = d - LONG_FLASH_UNITS;
            p.flen = LEN_FOUR;
        end else begin
            p.remaining = d - COUNT_W'(1);
            p.flen = LEN_ONE;
        end
        return p;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unit_reg <= UNIT_RESET;
        end else if (cfg_valid) begin
            unit_reg <= cfg_data;
        end
    end

    // Length of the current segment in ticks, held to 1 .. 2**TCW.
    always_comb begin
        case (phase_reg)
            PH_GAP:   raw_len = LEN_W'(unit_reg) << 2;
            PH_SPACE: raw_len = LEN_W'(unit_reg);
            PH_FLASH: begin
                case (flen_reg)
                    LEN_QUARTER: raw_len = LEN_W'(unit_reg >> 2);
                    LEN_FOUR:    raw_len = LEN_W'(unit_reg) << 2;
                    default:     raw_len = LEN_W'(unit_reg);
                endcase
            end
            default:  raw_len = LEN_W'(unit_reg);
        endcase
        if (raw_len == '0) begin
            seg_len = LEN_W'(1);
        end else if (raw_len > LEN_CAP) begin
            seg_len = LEN_CAP;
        end else begin
            seg_len = raw_len;
        end
    end

    assign tick_inc = LEN_W'(tick_reg) + LEN_W'(1);
    assign word_shifted = word_reg << NIBBLE_W;
    assign word_start = item.value << WORD_SHIFT;

    always_comb begin
        phase_next  = phase_reg;
        tick_next   = tick_reg;
        rem_next    = rem_reg;
        flen_next   = flen_reg;
        digits_next = digits_reg;
        word_next   = word_reg;
        led_next    = led_reg;
        done        = 1'b0;
        ignored     = 1'b0;
        plan        = flash_plan(rem_reg);

        case (item.kind)
            KIND_TICK: begin
                if (phase_reg != PH_IDLE) begin
                    if (tick_inc >= seg_len) begin
                        tick_next = '0;
                        case (phase_reg)
                            PH_FLASH: begin
                                phase_next = PH_SPACE;
                                led_next = 1'b0;
                            end
                            PH_SPACE: begin
                                if (rem_reg == '0) begin
                                    phase_next = PH_GAP;
                                    led_next = 1'b0;
                                end else begin
                                    rem_next = plan.remaining;
                                    flen_next = plan.flen;
                                    phase_next = PH_FLASH;
                                    led_next = 1'b1;
                                end
                            end
                            default: begin
                                if (digits_reg != '0) begin
                                    plan = flash_plan(COUNT_W'(
                                        word_shifted[VALUE_W-1 -: NIBBLE_W]));
                                    digits_next = digits_reg - DIGIT_CNT_W'(1);
                                    word_next = word_shifted;
                                    rem_next = plan.remaining;
                                    flen_next = plan.flen;
                                    phase_next = PH_FLASH;
                                    led_next = 1'b1;
                                end else begin
                                    phase_next = PH_IDLE;
                                    led_next = 1'b0;
                                    done = 1'b1;
                                end
                            end
                        endcase
                    end else begin
                        tick_next = tick_inc[TCW-1:0];
                    end
                end
            end
            KIND_WORD, KIND_COUNT: begin
                if (phase_reg != PH_IDLE) begin
                    ignored = 1'b1;
                end else begin
                    if (item.kind == KIND_WORD) begin
                        word_next = word_start;
                        digits_next = LAST_DIGIT & NIBBLE_MASK;
                        plan = flash_plan(COUNT_W'(word_start[VALUE_W-1 -: NIBBLE_W]));
                    end else begin
                        word_next = '0;
                        digits_next = '0;
                        plan = flash_plan(item.value[COUNT_W-1:0]);
                    end
                    rem_next = plan.remaining;
                    flen_next = plan.flen;
                    phase_next = PH_FLASH;
                    led_next = 1'b1;
                    tick_next = '0;
                end
            end
            default: begin
                // Unused kind code: no change and no flags.
            end
        endcase

        res.led = led_next;
        res.busy_res = (phase_next != PH_IDLE);
        res.done_res = done;
        res.start_ignored = ignored;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            tick_reg   <= '0;
            rem_reg    <= '0;
            flen_reg   <= LEN_QUARTER;
            digits_reg <= '0;
            word_reg   <= '0;
            led_reg    <= 1'b0;
        end else if (step) begin
            phase_reg  <= phase_next;
            tick_reg   <= tick_next;
            rem_reg    <= rem_next;
            flen_reg   <= flen_next;
            digits_reg <= digits_next;
            word_reg   <= word_next;
            led_reg    <= led_next;
        end
    end

endmodule

FILE: rtl/lbcg_out_stage.sv
module lbcg_out_stage (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               res_valid,
    input  lbcg_pkg::res_t                     res,
    output logic                               up_ready,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [lbcg_pkg::OUT_TDATA_W-1:0]   m_tdata
);
    import lbcg_pkg::*;

    logic valid_reg, valid_next;
    res_t res_reg;

    assign up_ready = !valid_reg || m_tready;

    always_comb begin
        if (res_valid) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata = OUT_TDATA_W'(res_reg);

endmodule

FILE: rtl/led_blink_code_generator.sv
// LED blink-code generator.
// Input stream: s_tuser carries the item kind (tick, start word, start count)
// and s_tdata the 32-bit value. Each input transaction yields exactly one
// result transaction on the m_ channel: LED level, busy, done and a flag for
// a start that arrived while a sequence was still running.
// Configuration: a write transaction on cfg_valid/cfg_data sets the number
// of ticks per blink unit; cfg_ready is always high. Write it only while idle.
// An input transaction passes the input register, then the state update and
// result register. One item is taken every cycle while the result receiver
// does not stall; the rate is set by the state update, which holds one add
// and compare of the tick counter against the segment length.
// When the result receiver stalls, the result register holds its transaction
// and the input register holds one more; s_tready falls only when both are
// full. Reset (aresetn low, synchronous) turns the LED off, ends any sequence,
// empties both registers and sets the blink unit to 0x100000 ticks.
module led_blink_code_generator #(
    parameter int DIGITS = 8,
    parameter int TICK_COUNT_WIDTH = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // value[31:0]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // led, busy_res, done_res, start_ignored, zeros
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [22:0] cfg_data   // blink_unit
);
    import lbcg_pkg::*;

    logic  item_valid, down_ready, step;
    item_t item;
    res_t  res;

    assign cfg_ready = 1'b1;
    assign step = item_valid && down_ready;

    lbcg_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .down_ready (down_ready),
        .item_valid (item_valid),
        .item       (item)
    );

    lbcg_core #(
        .DIGITS           (DIGITS),
        .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .step      (step),
        .item      (item),
        .res       (res)
    );

    lbcg_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (step),
        .res       (res),
        .up_ready  (down_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
